// ===== hw/rtl/oscillator_trim_calibrator_defines.svh =====
// Assertion macros shared by the trim calibrator RTL.
// Expects aclk and aresetn in scope at the point of use.
`ifndef OSCILLATOR_TRIM_CALIBRATOR_DEFINES_SVH
`define OSCILLATOR_TRIM_CALIBRATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OTC_ASSERT_IMM(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define OTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/otc_pkg.sv =====
// Shared types, codes and constants of the oscillator trim calibrator.
// No dependencies.
package otc_pkg;

    localparam int SweepOffsetDefault = 8;
    localparam int TrimMin  = 5;
    localparam int TrimMax  = 505;
    localparam int TrimSafe = 256;
    localparam int ByteMin  = TrimMin / 2;
    localparam int ByteMax  = TrimMax / 2;

    typedef struct packed {
        logic        func;
        logic [25:0] measured_freq;
    } otc_in_t;

    typedef struct packed {
        logic [8:0]  next_trim;
        logic [2:0]  phase;
        logic        done_res;
        logic        trim_error;
        logic [29:0] measured_bus_freq;
    } otc_out_t;

    typedef enum logic [1:0] {
        CFG_TARGET = 2'd0,
        CFG_FACTOR = 2'd1,
        CFG_NINE   = 2'd2
    } otc_cfg_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SEARCH = 3'd1,
        PH_DOWN   = 3'd2,
        PH_UP     = 3'd3,
        PH_FINAL  = 3'd4
    } otc_phase_t;

    // Multiply-accumulate passes of the line fit, in issue order.
    typedef enum logic [3:0] {
        FOP_N_SXY,
        FOP_SX_SY,
        FOP_N_SXX,
        FOP_SX_SX,
        FOP_N_T,
        FOP_SY,
        FOP_DY_BD,
        FOP_BN_SX,
        FOP_BN_N,
        FOP_P_LO,
        FOP_Q5,
        FOP_P_HI,
        FOP_Q505
    } otc_fop_t;

    typedef enum logic [3:0] {
        ST_IN,
        ST_TDIV_GO,
        ST_TDIV_WAIT,
        ST_EXEC,
        ST_PICK,
        ST_FIT_GO,
        ST_FIT_WAIT,
        ST_NORM,
        ST_FIN,
        ST_FDIV_GO,
        ST_FDIV_WAIT,
        ST_OUT
    } otc_state_t;

    typedef struct packed {
        logic     cap;
        logic     t_start;
        logic     t_store;
        logic     exec;
        logic     pick;
        logic     mul_start;
        logic     mul_finish;
        otc_fop_t fop;
        logic     norm;
        logic     f_start;
        logic     fin_bad;
        logic     fin_div;
        logic     out_load;
    } otc_cmd_t;

    typedef struct packed {
        logic exec_pick;
        logic pick_found;
        logic pick_exhausted;
        logic mul_busy;
        logic div_busy;
        logic bad;
    } otc_stat_t;

endpackage

// ===== hw/rtl/oscillator_trim_calibrator.sv =====
// Top level of the oscillator trim calibrator: configuration registers and
// the sequencer/datapath pair. Depends on otc_pkg, otc_ctrl and otc_dp.
//
// Usage: a word on the s_ channel with func 0 starts a calibration run; a word
// with func 1 carries one frequency measurement taken at the trim that the
// previous result asked for. Every accepted word yields exactly one result word
// on the m_ channel, naming the next trim, the run phase, and on the final
// measurement the done flag and the scaled bus frequency.
// Each measurement or start word runs the 32-step serial divide of the target
// frequency by the bus factor before its result is formed. Words that move
// the sweep to a new trim also examine the candidate trims one at a time. The
// word that ends the sweep also runs the line fit: thirteen shift-add passes,
// each running over the set bits' span of its narrow operand, then a 9-step
// divide unless the fit proves bad. One word is in work at a time.
// The result sits in an output register; a new word is accepted while it
// waits, and the block only holds off if a second result is ready before the
// first is taken. Reset (aresetn low, synchronous) returns the block to idle,
// trim 256, with the bus factor and the 9-bit trim mode set to 1.
// Configuration is written through cfg_we, cfg_index and cfg_wdata.
module oscillator_trim_calibrator import otc_pkg::*; #(
    parameter int SWEEP_OFFSET = SweepOffsetDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  otc_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output otc_out_t    m_data
);

    // Configuration registers; the user must write them only between words (unenforced).
    logic [31:0] target_reg;
    logic [4:0]  factor_reg;
    logic        nine_reg;

    otc_cmd_t  cmd;
    otc_stat_t st;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            factor_reg <= 5'd1;
            nine_reg   <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TARGET: target_reg <= cfg_wdata;
                CFG_FACTOR: factor_reg <= cfg_wdata[4:0];
                CFG_NINE:   nine_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // The sequencer owns both handshakes and steps the datapath.
    otc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // The datapath holds the run state, the sums and the arithmetic units.
    otc_dp #(
        .SWEEP_OFFSET (SWEEP_OFFSET)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .target_bus_freq (target_reg),
        .bus_factor      (factor_reg),
        .nine_bit_trim   (nine_reg),
        .s_word          (s_data),
        .cmd             (cmd),
        .st              (st),
        .out_word        (m_data)
    );

endmodule

// ===== hw/rtl/otc_dp.sv =====
// Datapath of the trim calibrator: run state, sums, serial multiplier and divider.
// Depends on otc_pkg.
module otc_dp import otc_pkg::*; #(
    parameter int SWEEP_OFFSET = SweepOffsetDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] target_bus_freq,
    input  logic [4:0]  bus_factor,
    input  logic        nine_bit_trim,
    input  otc_in_t     s_word,
    input  otc_cmd_t    cmd,
    output otc_stat_t   st,
    output otc_out_t    out_word
);

    // Every trim is visited at most twice per run, at most four times each.
    localparam int NMax = 8 * (2 * SWEEP_OFFSET + 1);
    localparam int NW   = $clog2(NMax + 1);
    localparam int SxW  = $clog2(NMax * TrimMax + 1);
    localparam int SxxW = $clog2(NMax * TrimMax * TrimMax + 1);
    localparam int SyW  = NW + 26;
    localparam int SxyW = SxW + 26;
    localparam int BnW  = NW + SxyW + 1;
    localparam int BdW  = NW + SxxW;
    localparam int DyW  = NW + 33;
    localparam int P1W  = DyW - 1 + BdW;
    localparam int P2W  = BnW - 1 + SxW;
    localparam int PW   = ((P1W > P2W) ? P1W : P2W) + 2;
    localparam int QW   = BnW - 1 + NW + 11;
    localparam int W    = ((PW > QW) ? PW : QW) + 1;
    localparam int MbW  = (BdW > SxW) ? BdW : SxW;

    logic              func_reg;
    logic [25:0]       meas_reg;
    logic [31:0]       t_reg;
    otc_phase_t        phase_reg;
    logic [7:0]        byte_reg;
    logic [7:0]        bit_reg;
    logic [8:0]        cur_reg;
    logic [8:0]        low_reg;
    logic [8:0]        high_reg;
    logic [1:0]        rep_reg;
    logic [NW-1:0]     n_reg;
    logic [SxW-1:0]    sx_reg;
    logic [SxxW-1:0]   sxx_reg;
    logic [SyW-1:0]    sy_reg;
    logic [SxyW-1:0]   sxy_reg;
    logic              fail_reg;
    logic [9:0]        cand_reg;
    logic              dir_up_reg;
    logic [W-1:0]      ma_reg;
    logic [MbW-1:0]    mb_reg;
    logic              mneg_reg;
    logic signed [W-1:0]   acc_reg;
    logic signed [BnW-1:0] bn_reg;
    logic [BdW-1:0]        bd_reg;
    logic signed [DyW-1:0] dy_reg;
    logic signed [W-1:0]   p_reg;
    logic signed [W-1:0]   q_reg;
    logic              bad_reg;
    logic [W-1:0]      rem_reg;
    logic [W-1:0]      den_reg;
    logic [31:0]       quo_reg;
    logic [5:0]        dcnt_reg;
    logic              done_reg;
    logic [29:0]       mbf_reg;
    otc_out_t          out_reg;

    logic [4:0]  eff;
    logic [7:0]  trial0;
    logic [7:0]  trial1;
    logic [7:0]  trial;
    logic [7:0]  bit_n;
    logic [8:0]  centre;
    logic [9:0]  hi_s;
    logic [8:0]  hi;
    logic [8:0]  lo;
    logic [2:0]  reps;
    logic [2:0]  rep_n;
    logic        rep_hit;
    logic [17:0] tt;
    logic [34:0] tm;
    logic [30:0] mbf_full;
    logic        in_rng;
    logic        usable;
    logic signed [W-1:0] a_s;
    logic [W-1:0]   a_mag;
    logic [MbW-1:0] b_sel;
    logic           sub_sel;
    logic           clr_sel;
    logic           div_ge;

    assign eff      = (bus_factor == 5'd0) ? 5'd1 : bus_factor;
    assign trial0   = byte_reg | bit_reg;
    assign trial1   = (32'(meas_reg) < t_reg) ? (trial0 & ~bit_reg) : trial0;
    assign trial    = (trial1 > 8'(ByteMax)) ? 8'(ByteMax) :
                      (trial1 < 8'(ByteMin)) ? 8'(ByteMin) : trial1;
    assign bit_n    = bit_reg >> 1;
    assign centre   = {trial, 1'b0};
    assign hi_s     = 10'(centre) + 10'(SWEEP_OFFSET);
    assign hi       = (hi_s > 10'(TrimMax)) ? 9'(TrimMax) : hi_s[8:0];
    assign lo       = (centre < 9'(SWEEP_OFFSET + TrimMin)) ? 9'(TrimMin)
                                                            : centre - 9'(SWEEP_OFFSET);
    assign reps     = nine_bit_trim ? 3'd2 : 3'd4;
    assign rep_n    = 3'(rep_reg) + 3'd1;
    assign rep_hit  = rep_n >= reps;
    assign tt       = 18'(cur_reg) * 18'(cur_reg);
    assign tm       = 35'(cur_reg) * 35'(meas_reg);
    assign mbf_full = 31'(meas_reg) * 31'(eff);
    assign in_rng   = (cand_reg >= 10'(low_reg)) && (cand_reg <= 10'(high_reg));
    assign usable   = nine_bit_trim || !cand_reg[0];
    assign div_ge   = rem_reg >= den_reg;

    // Operand selection for one multiply-accumulate pass.
    always_comb begin
        a_s     = '0;
        b_sel   = '0;
        sub_sel = 1'b0;
        clr_sel = 1'b0;
        unique case (cmd.fop)
            FOP_N_SXY: begin
                a_s = signed'(W'(sxy_reg)); b_sel = MbW'(n_reg); clr_sel = 1'b1;
            end
            FOP_SX_SY: begin
                a_s = signed'(W'(sy_reg)); b_sel = MbW'(sx_reg); sub_sel = 1'b1;
            end
            FOP_N_SXX: begin
                a_s = signed'(W'(sxx_reg)); b_sel = MbW'(n_reg); clr_sel = 1'b1;
            end
            FOP_SX_SX: begin
                a_s = signed'(W'(sx_reg)); b_sel = MbW'(sx_reg); sub_sel = 1'b1;
            end
            FOP_N_T: begin
                a_s = signed'(W'(t_reg)); b_sel = MbW'(n_reg); clr_sel = 1'b1;
            end
            FOP_SY: begin
                a_s = signed'(W'(sy_reg)); b_sel = MbW'(1); sub_sel = 1'b1;
            end
            FOP_DY_BD: begin
                a_s = W'(dy_reg); b_sel = MbW'(bd_reg); clr_sel = 1'b1;
            end
            FOP_BN_SX: begin
                a_s = W'(bn_reg); b_sel = MbW'(sx_reg);
            end
            FOP_BN_N: begin
                a_s = W'(bn_reg); b_sel = MbW'(n_reg); clr_sel = 1'b1;
            end
            FOP_P_LO: begin
                a_s = p_reg; b_sel = MbW'(1); clr_sel = 1'b1;
            end
            FOP_Q5: begin
                a_s = q_reg; b_sel = MbW'(TrimMin); sub_sel = 1'b1;
            end
            FOP_P_HI: begin
                a_s = p_reg; b_sel = MbW'(1); clr_sel = 1'b1;
            end
            FOP_Q505: begin
                a_s = q_reg; b_sel = MbW'(TrimMax); sub_sel = 1'b1;
            end
            default: ;
        endcase
        a_mag = a_s[W-1] ? W'(-a_s) : W'(a_s);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            func_reg   <= 1'b0;
            meas_reg   <= '0;
            t_reg      <= '0;
            phase_reg  <= PH_IDLE;
            byte_reg   <= '0;
            bit_reg    <= 8'h80;
            cur_reg    <= 9'(TrimSafe);
            low_reg    <= '0;
            high_reg   <= '0;
            rep_reg    <= '0;
            n_reg      <= '0;
            sx_reg     <= '0;
            sxx_reg    <= '0;
            sy_reg     <= '0;
            sxy_reg    <= '0;
            fail_reg   <= 1'b0;
            cand_reg   <= '0;
            dir_up_reg <= 1'b0;
            ma_reg     <= '0;
            mb_reg     <= '0;
            mneg_reg   <= 1'b0;
            acc_reg    <= '0;
            bn_reg     <= '0;
            bd_reg     <= '0;
            dy_reg     <= '0;
            p_reg      <= '0;
            q_reg      <= '0;
            bad_reg    <= 1'b0;
            rem_reg    <= '0;
            den_reg    <= '0;
            quo_reg    <= '0;
            dcnt_reg   <= '0;
            done_reg   <= 1'b0;
            mbf_reg    <= '0;
            out_reg    <= '0;
        end else begin
            if (cmd.cap) begin
                func_reg <= s_word.func;
                meas_reg <= s_word.measured_freq;
            end

            // Shared restoring divider, one quotient bit per cycle.
            if (cmd.t_start) begin
                rem_reg  <= W'(target_bus_freq);
                den_reg  <= W'({eff, 31'd0});
                dcnt_reg <= 6'd32;
            end else if (cmd.f_start) begin
                rem_reg  <= {p_reg[W-2:0], 1'b0} + q_reg;
                den_reg  <= {q_reg[W-10:0], 9'd0};
                dcnt_reg <= 6'd9;
            end else if (dcnt_reg != 6'd0) begin
                if (div_ge) begin
                    rem_reg <= rem_reg - den_reg;
                end
                quo_reg  <= {quo_reg[30:0], div_ge};
                den_reg  <= den_reg >> 1;
                dcnt_reg <= dcnt_reg - 6'd1;
            end
            if (cmd.t_store) begin
                t_reg <= quo_reg;
            end

            // Shift-add multiplier accumulating straight into acc_reg.
            if (cmd.mul_start) begin
                ma_reg   <= a_mag;
                mb_reg   <= b_sel;
                mneg_reg <= a_s[W-1] ^ sub_sel;
                if (clr_sel) begin
                    acc_reg <= '0;
                end
            end else if (mb_reg != '0) begin
                if (mb_reg[0]) begin
                    acc_reg <= mneg_reg ? acc_reg - $signed(ma_reg)
                                        : acc_reg + $signed(ma_reg);
                end
                ma_reg <= ma_reg << 1;
                mb_reg <= mb_reg >> 1;
            end
            if (cmd.mul_finish) begin
                unique case (cmd.fop)
                    FOP_SX_SY: bn_reg  <= acc_reg[BnW-1:0];
                    FOP_SX_SX: bd_reg  <= acc_reg[BdW-1:0];
                    FOP_SY:    dy_reg  <= acc_reg[DyW-1:0];
                    FOP_BN_SX: p_reg   <= acc_reg;
                    FOP_BN_N:  q_reg   <= acc_reg;
                    FOP_Q5:    bad_reg <= bad_reg | acc_reg[W-1] | (acc_reg == '0);
                    FOP_Q505:  bad_reg <= bad_reg | !acc_reg[W-1];
                    default: ;
                endcase
            end
            if (cmd.norm) begin
                bad_reg <= (q_reg == '0);
                if (q_reg[W-1]) begin
                    q_reg <= -q_reg;
                    p_reg <= -p_reg;
                end
            end

            if (cmd.fin_bad) begin
                cur_reg   <= 9'(TrimSafe);
                fail_reg  <= 1'b1;
                phase_reg <= PH_FINAL;
            end
            if (cmd.fin_div) begin
                cur_reg   <= quo_reg[8:0];
                phase_reg <= PH_FINAL;
            end

            if (cmd.pick) begin
                if (in_rng) begin
                    if (usable) begin
                        cur_reg   <= cand_reg[8:0];
                        phase_reg <= dir_up_reg ? PH_UP : PH_DOWN;
                    end else begin
                        cand_reg <= dir_up_reg ? cand_reg + 10'd1 : cand_reg - 10'd1;
                    end
                end else if (!dir_up_reg) begin
                    dir_up_reg <= 1'b1;
                    cand_reg   <= 10'(low_reg);
                end
            end

            if (cmd.exec) begin
                done_reg <= 1'b0;
                mbf_reg  <= '0;
                if (!func_reg) begin
                    phase_reg <= PH_SEARCH;
                    byte_reg  <= '0;
                    bit_reg   <= 8'h80;
                    cur_reg   <= 9'(TrimSafe);
                    rep_reg   <= '0;
                    n_reg     <= '0;
                    sx_reg    <= '0;
                    sxx_reg   <= '0;
                    sy_reg    <= '0;
                    sxy_reg   <= '0;
                    fail_reg  <= 1'b0;
                end else begin
                    unique case (phase_reg)
                        PH_SEARCH: begin
                            byte_reg <= trial;
                            bit_reg  <= bit_n;
                            if (bit_n != 8'd0) begin
                                cur_reg <= {trial | bit_n, 1'b0};
                            end else begin
                                low_reg    <= lo;
                                high_reg   <= hi;
                                rep_reg    <= '0;
                                cand_reg   <= 10'(hi);
                                dir_up_reg <= 1'b0;
                            end
                        end
                        PH_DOWN, PH_UP: begin
                            sx_reg  <= sx_reg + SxW'(cur_reg);
                            sxx_reg <= sxx_reg + SxxW'(tt);
                            sy_reg  <= sy_reg + SyW'(meas_reg);
                            sxy_reg <= sxy_reg + SxyW'(tm);
                            n_reg   <= n_reg + NW'(1);
                            if (rep_hit) begin
                                rep_reg    <= '0;
                                cand_reg   <= (phase_reg == PH_DOWN) ? 10'(cur_reg) - 10'd1
                                                                     : 10'(cur_reg) + 10'd1;
                                dir_up_reg <= (phase_reg == PH_UP);
                            end else begin
                                rep_reg <= rep_n[1:0];
                            end
                        end
                        PH_FINAL: begin
                            mbf_reg   <= (mbf_full > 31'h3FFF_FFFF) ? 30'h3FFF_FFFF
                                                                   : mbf_full[29:0];
                            done_reg  <= 1'b1;
                            phase_reg <= PH_IDLE;
                        end
                        PH_IDLE: ;
                        default: ;
                    endcase
                end
            end

            if (cmd.out_load) begin
                out_reg.next_trim         <= cur_reg;
                out_reg.phase             <= phase_reg;
                out_reg.done_res          <= done_reg;
                out_reg.trim_error        <= fail_reg;
                out_reg.measured_bus_freq <= mbf_reg;
            end
        end
    end

    assign st.exec_pick = func_reg &&
                          (((phase_reg == PH_SEARCH) && (bit_n == 8'd0)) ||
                           (((phase_reg == PH_DOWN) || (phase_reg == PH_UP)) && rep_hit));
    assign st.pick_found     = in_rng && usable;
    assign st.pick_exhausted = !in_rng && dir_up_reg;
    assign st.mul_busy       = (mb_reg != '0);
    assign st.div_busy       = (dcnt_reg != 6'd0);
    assign st.bad            = bad_reg;
    assign out_word          = out_reg;

endmodule

// ===== hw/rtl/otc_ctrl.sv =====
// Sequencer of the trim calibrator: handshakes and datapath command issue.
// Depends on otc_pkg and oscillator_trim_calibrator_defines.svh.
`include "oscillator_trim_calibrator_defines.svh"

module otc_ctrl import otc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  otc_stat_t st,
    output otc_cmd_t  cmd
);

    otc_state_t state_reg, state_next;
    otc_fop_t   op_reg, op_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IN;
            op_reg      <= FOP_N_SXY;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.fop      = op_reg;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IN: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.cap    = 1'b1;
                    state_next = ST_TDIV_GO;
                end
            end
            ST_TDIV_GO: begin
                cmd.t_start = 1'b1;
                state_next  = ST_TDIV_WAIT;
            end
            ST_TDIV_WAIT: begin
                if (!st.div_busy) begin
                    cmd.t_store = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = st.exec_pick ? ST_PICK : ST_OUT;
            end
            ST_PICK: begin
                cmd.pick = 1'b1;
                if (st.pick_found) begin
                    state_next = ST_OUT;
                end else if (st.pick_exhausted) begin
                    op_next    = FOP_N_SXY;
                    state_next = ST_FIT_GO;
                end
            end
            ST_FIT_GO: begin
                cmd.mul_start = 1'b1;
                state_next    = ST_FIT_WAIT;
            end
            ST_FIT_WAIT: begin
                if (!st.mul_busy) begin
                    cmd.mul_finish = 1'b1;
                    state_next     = ST_FIT_GO;
                    unique case (op_reg)
                        FOP_N_SXY: op_next = FOP_SX_SY;
                        FOP_SX_SY: op_next = FOP_N_SXX;
                        FOP_N_SXX: op_next = FOP_SX_SX;
                        FOP_SX_SX: op_next = FOP_N_T;
                        FOP_N_T:   op_next = FOP_SY;
                        FOP_SY:    op_next = FOP_DY_BD;
                        FOP_DY_BD: op_next = FOP_BN_SX;
                        FOP_BN_SX: op_next = FOP_BN_N;
                        FOP_BN_N:  state_next = ST_NORM;
                        FOP_P_LO:  op_next = FOP_Q5;
                        FOP_Q5:    op_next = FOP_P_HI;
                        FOP_P_HI:  op_next = FOP_Q505;
                        FOP_Q505:  state_next = ST_FIN;
                        default:   state_next = ST_FIN;
                    endcase
                end
            end
            ST_NORM: begin
                cmd.norm   = 1'b1;
                op_next    = FOP_P_LO;
                state_next = ST_FIT_GO;
            end
            ST_FIN: begin
                if (st.bad) begin
                    cmd.fin_bad = 1'b1;
                    state_next  = ST_OUT;
                end else begin
                    state_next = ST_FDIV_GO;
                end
            end
            ST_FDIV_GO: begin
                cmd.f_start = 1'b1;
                state_next  = ST_FDIV_WAIT;
            end
            ST_FDIV_WAIT: begin
                if (!st.div_busy) begin
                    cmd.fin_div = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IN;
                end
            end
            default: state_next = ST_IN;
        endcase
    end

    assign m_valid = m_valid_reg;

    `OTC_ASSERT_IMM(a_idle_units, s_ready, !st.mul_busy && !st.div_busy, "unit busy while taking a word")
    `OTC_ASSERT_IMM(a_out_free, cmd.out_load, !m_valid_reg || m_ready, "result register overwritten")
    `OTC_ASSERT_NEXT(a_div_runs, state_reg == ST_TDIV_GO, st.div_busy, "target divide did not start")

endmodule
